/* hw/rtl/lrtm_pkg.sv */
// lrtm_pkg: shared types and constants for the linear recurrence term block
// no dependencies
`default_nettype none

package lrtm_pkg;

    localparam int IDX_W = 60;
    localparam int VAL_W = 30;
    localparam int ORD_W = 7;
    localparam logic [VAL_W-1:0] PRIME = 30'd1000000007;
    localparam logic [ORD_W-1:0] ORDER_RESET = 7'd2;
    // floor(2^60 / prime) for barrett reduction of a 60-bit product
    localparam logic [30:0] BARRETT_MU = 31'((64'd1 << 60) / 64'(PRIME));

    // multiply-accumulate unit request
    typedef struct packed {
        logic             clear;
        logic             valid;
        logic [VAL_W-1:0] a;
        logic [VAL_W-1:0] b;
    } lrtm_mac_req_t;

endpackage

`default_nettype wire

/* hw/rtl/lrtm_if.sv */
// lrtm_if: valid/ready channel carrying a payload of configurable width
// depends on nothing
`default_nettype none

interface lrtm_if #(
    parameter int W = 8
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/lrtm_ram.sv */
// lrtm_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module lrtm_ram #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* hw/rtl/lrtm_mac.sv */
// lrtm_mac: pipelined modular multiply-accumulate, acc = (acc + a*b) mod prime
// depends on lrtm_pkg
`default_nettype none

module lrtm_mac
    import lrtm_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire lrtm_mac_req_t req,
    output logic [VAL_W-1:0]   acc,
    output logic               busy
);

    // barrett reduction: product, quotient estimate, quotient times prime,
    // then the remainder with at most two corrections
    localparam int NST = 3;
    localparam logic [31:0] P1 = {2'b00, PRIME};
    localparam logic [31:0] P2 = {1'b0, PRIME, 1'b0};

    logic [59:0]      prod_reg;
    logic [59:0]      prod1_reg;
    logic [61:0]      qest_reg;
    logic [31:0]      prod2_reg;
    logic [31:0]      qp_reg;
    logic [VAL_W-1:0] rem_reg;
    logic             v_reg [NST+1];
    logic             clr_reg [NST+1];
    logic [VAL_W-1:0] acc_reg;
    logic [31:0]      diff;
    logic [31:0]      red;

    always_comb
    begin
        diff = prod2_reg - qp_reg;
        if (diff >= P2)
        begin
            red = diff - P2;
        end
        else if (diff >= P1)
        begin
            red = diff - P1;
        end
        else
        begin
            red = diff;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg  <= 60'(req.a) * 60'(req.b);
        prod1_reg <= prod_reg;
        qest_reg  <= 62'(prod_reg[59:29]) * 62'(BARRETT_MU);
        prod2_reg <= prod1_reg[31:0];
        qp_reg    <= 32'(qest_reg[61:31]) * 32'(PRIME);
        rem_reg   <= red[VAL_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= NST; i++)
            begin
                v_reg[i]   <= 1'b0;
                clr_reg[i] <= 1'b0;
            end
            acc_reg <= '0;
        end
        else
        begin
            v_reg[0]   <= req.valid;
            clr_reg[0] <= req.clear;
            for (int i = 1; i <= NST; i++)
            begin
                v_reg[i]   <= v_reg[i-1];
                clr_reg[i] <= clr_reg[i-1];
            end
            if (clr_reg[NST])
            begin
                acc_reg <= '0;
            end
            if (v_reg[NST])
            begin
                logic [30:0] t;
                t = {1'b0, (clr_reg[NST] ? 30'd0 : acc_reg)} + {1'b0, rem_reg};
                acc_reg <= (t >= {1'b0, PRIME}) ? 30'(t - {1'b0, PRIME}) : t[29:0];
            end
        end
    end

    always_comb
    begin
        busy = 1'b0;
        for (int i = 0; i <= NST; i++)
        begin
            busy = busy | v_reg[i] | clr_reg[i];
        end
    end

    assign acc = acc_reg;

endmodule

`default_nettype wire

/* hw/rtl/linear_recurrence_term_mod_prime_top.sv */
// linear_recurrence_term_mod_prime_top: n-th term of f(k)=f(k-1)+f(k-m) modulo 1000000007
// depends on lrtm_pkg, lrtm_if, lrtm_ram, lrtm_mac
//
// usage:
//   cfg_we/cfg_data write the order m (values below 2 act as 2, above MAX_ORDER
//   as MAX_ORDER); write only while idle. term_in carries term_index, term_out
//   term_value, both valid/ready channels; one result per transfer.
//   for n < m the result is valid the cycle after the transfer. otherwise the
//   sequencer fills the companion matrix and identity, then for each bit of
//   n-1 performs up to two m*m*m matrix products on the single pipelined
//   multiply-accumulate unit, each followed by an m*m copy back from scratch.
//   squared_base keeps a second copy so a square reads two operands per cycle.
//   term_in is not ready while an item is in work. the result sits in an output
//   register until taken; a stalled receiver holds the block, no result is lost.
//   reset returns the order to 2 and the sequencer to idle; matrix stores are
//   not cleared since every entry read is written earlier in the same item.
`default_nettype none

module linear_recurrence_term_mod_prime_top
    import lrtm_pkg::*;
#(
    parameter int MAX_ORDER = 64
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [ORD_W-1:0] cfg_data,
    lrtm_if.sink                  term_in,
    lrtm_if.source                term_out
);

    localparam int MW = $clog2(MAX_ORDER);
    localparam int AW = 2 * MW;
    localparam int CW = MW + 1;

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b0000000001,
        ST_INIT  = 10'b0000000010,
        ST_BIT   = 10'b0000000100,
        ST_MUL   = 10'b0000001000,
        ST_DRAIN = 10'b0000010000,
        ST_COPY  = 10'b0000100000,
        ST_FIN   = 10'b0001000000,
        ST_FDRN  = 10'b0010000000,
        ST_OUT   = 10'b0100000000,
        ST_NEXT  = 10'b1000000000
    } state_t;

    state_t           state_reg, state_next;
    logic [ORD_W-1:0] order_reg;
    logic [CW-1:0]    m;
    logic [IDX_W-1:0] exp_reg, exp_next;
    logic             tgt_reg, tgt_next;       // 1: squared_base is destination
    logic [MW-1:0]    i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic             kdone_reg, kdone_next;   // operand issue finished
    logic [VAL_W-1:0] res_reg, res_next;
    logic             ovalid_reg, ovalid_next;
    logic             cpv_reg;                 // copy read in flight
    logic [AW-1:0]    cpa_reg;

    lrtm_mac_req_t    req;
    logic [VAL_W-1:0] acc;
    logic             busy;

    logic             pa_we, sb_we, ps_we;
    logic [AW-1:0]    pa_wa, sb_wa, ps_wa, pa_ra, sb_ra, ps_ra, sq_ra;
    logic [VAL_W-1:0] pa_wd, sb_wd, ps_wd, pa_rd, sb_rd, ps_rd, sq_rd;
    logic             rd_v_reg, rd_c_reg;

    always_comb
    begin
        if (order_reg < 7'd2)
        begin
            m = CW'(2);
        end
        else if (32'(order_reg) > MAX_ORDER)
        begin
            m = CW'(MAX_ORDER);
        end
        else
        begin
            m = CW'(order_reg);
        end
    end

    function automatic logic [AW-1:0] addr(input logic [MW-1:0] r, input logic [MW-1:0] c);
        return {r, c};
    endfunction

    logic [MW-1:0] mlast;
    assign mlast = MW'(m - CW'(1));

    lrtm_ram #(.WIDTH(VAL_W), .DEPTH(2 ** AW)) u_pa (
        .clk(clk), .we(pa_we), .waddr(pa_wa), .wdata(pa_wd), .raddr(pa_ra), .rdata(pa_rd));
    lrtm_ram #(.WIDTH(VAL_W), .DEPTH(2 ** AW)) u_sb (
        .clk(clk), .we(sb_we), .waddr(sb_wa), .wdata(sb_wd), .raddr(sb_ra), .rdata(sb_rd));
    lrtm_ram #(.WIDTH(VAL_W), .DEPTH(2 ** AW)) u_sq (
        .clk(clk), .we(sb_we), .waddr(sb_wa), .wdata(sb_wd), .raddr(sq_ra), .rdata(sq_rd));
    lrtm_ram #(.WIDTH(VAL_W), .DEPTH(2 ** AW)) u_ps (
        .clk(clk), .we(ps_we), .waddr(ps_wa), .wdata(ps_wd), .raddr(ps_ra), .rdata(ps_rd));

    lrtm_mac u_mac (.clk(clk), .rst_n(rst_n), .req(req), .acc(acc), .busy(busy));

    logic issue;
    assign issue = (state_reg == ST_MUL) && !kdone_reg;
    logic fissue;
    assign fissue = (state_reg == ST_FIN) && !kdone_reg;

    // operand read addresses
    always_comb
    begin
        pa_ra = addr(i_reg, k_reg);
        sb_ra = tgt_reg ? addr(i_reg, k_reg) : addr(k_reg, j_reg);
        sq_ra = addr(k_reg, j_reg);
        ps_ra = addr(i_reg, j_reg);
        if (fissue)
        begin
            pa_ra = addr('0, k_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_v_reg <= 1'b0;
            rd_c_reg <= 1'b0;
        end
        else
        begin
            rd_v_reg <= issue || fissue;
            rd_c_reg <= (issue || fissue) && (k_reg == '0);
        end
    end

    logic fin_reg;
    logic two_reg;
    always_ff @(posedge clk)
    begin
        fin_reg <= fissue;
        two_reg <= fissue && (k_reg == mlast);
    end

    always_comb
    begin
        req.valid = rd_v_reg;
        req.clear = rd_c_reg;
        if (fin_reg)
        begin
            req.a = pa_rd;
            req.b = two_reg ? VAL_W'(2) : VAL_W'(1);
        end
        else
        begin
            req.a = tgt_reg ? sb_rd : pa_rd;
            req.b = tgt_reg ? sq_rd : sb_rd;
        end
    end

    // store writes
    always_comb
    begin
        pa_we = 1'b0;
        sb_we = 1'b0;
        ps_we = 1'b0;
        pa_wa = addr(i_reg, j_reg);
        sb_wa = addr(i_reg, j_reg);
        ps_wa = addr(i_reg, j_reg);
        pa_wd = (i_reg == j_reg) ? VAL_W'(1) : VAL_W'(0);
        sb_wd = VAL_W'(((j_reg == i_reg + MW'(1)) && (i_reg != mlast))
                     || ((i_reg == mlast) && ((j_reg == '0) || (j_reg == mlast))));
        ps_wd = acc;
        case (state_reg)
            ST_INIT:
            begin
                pa_we = 1'b1;
                sb_we = 1'b1;
            end
            ST_DRAIN:
            begin
                ps_we = !busy;
            end
            default:
            begin
            end
        endcase
        if (cpv_reg)
        begin
            pa_wa = cpa_reg;
            sb_wa = cpa_reg;
            pa_wd = ps_rd;
            sb_wd = ps_rd;
            pa_we = !tgt_reg;
            sb_we = tgt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cpv_reg <= 1'b0;
        end
        else
        begin
            cpv_reg <= (state_reg == ST_COPY);
        end
    end

    always_ff @(posedge clk)
    begin
        cpa_reg <= addr(i_reg, j_reg);
    end

    always_comb
    begin
        state_next  = state_reg;
        exp_next    = exp_reg;
        tgt_next    = tgt_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        k_next      = k_reg;
        kdone_next  = kdone_reg;
        res_next    = res_reg;
        ovalid_next = ovalid_reg;
        if (ovalid_reg && term_out.ready)
        begin
            ovalid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (term_in.valid && !ovalid_reg)
                begin
                    i_next = '0;
                    j_next = '0;
                    exp_next = term_in.data - IDX_W'(1);
                    if (term_in.data < IDX_W'(m))
                    begin
                        res_next = VAL_W'(1);
                        ovalid_next = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_INIT;
                    end
                end
            end
            ST_INIT:
            begin
                j_next = j_reg + MW'(1);
                if (j_reg == mlast)
                begin
                    j_next = '0;
                    i_next = i_reg + MW'(1);
                    if (i_reg == mlast)
                    begin
                        i_next = '0;
                        state_next = ST_BIT;
                    end
                end
            end
            ST_BIT:
            begin
                i_next = '0;
                j_next = '0;
                k_next = '0;
                kdone_next = 1'b0;
                if (exp_reg == '0)
                begin
                    state_next = ST_FIN;
                end
                else if (!tgt_reg && exp_reg[0])
                begin
                    state_next = ST_MUL;
                end
                else if (!tgt_reg)
                begin
                    tgt_next = 1'b1;
                    exp_next = exp_reg >> 1;
                    if ((exp_reg >> 1) != '0)
                    begin
                        state_next = ST_MUL;
                    end
                    else
                    begin
                        tgt_next = 1'b0;
                    end
                end
                else
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                k_next = k_reg + MW'(1);
                if (k_reg == mlast)
                begin
                    k_next = '0;
                    kdone_next = 1'b1;
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!busy)
                begin
                    kdone_next = 1'b0;
                    state_next = ST_MUL;
                    j_next = j_reg + MW'(1);
                    if (j_reg == mlast)
                    begin
                        j_next = '0;
                        i_next = i_reg + MW'(1);
                        if (i_reg == mlast)
                        begin
                            i_next = '0;
                            state_next = ST_COPY;
                        end
                    end
                end
            end
            ST_COPY:
            begin
                j_next = j_reg + MW'(1);
                if (j_reg == mlast)
                begin
                    j_next = '0;
                    i_next = i_reg + MW'(1);
                    if (i_reg == mlast)
                    begin
                        i_next = '0;
                        state_next = ST_NEXT;
                    end
                end
            end
            ST_NEXT:
            begin
                // after the multiply comes the shift and optional square; after a square, back to the bit step
                if (!tgt_reg)
                begin
                    tgt_next = 1'b1;
                    exp_next = exp_reg >> 1;
                    state_next = ((exp_reg >> 1) != '0) ? ST_MUL : ST_BIT;
                    kdone_next = 1'b0;
                    if ((exp_reg >> 1) == '0)
                    begin
                        tgt_next = 1'b0;
                    end
                end
                else
                begin
                    tgt_next = 1'b0;
                    state_next = ST_BIT;
                end
            end
            ST_FIN:
            begin
                k_next = k_reg + MW'(1);
                if (k_reg == mlast)
                begin
                    k_next = '0;
                    kdone_next = 1'b1;
                    state_next = ST_FDRN;
                end
            end
            ST_FDRN:
            begin
                if (!busy)
                begin
                    res_next = acc;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!ovalid_reg)
                begin
                    ovalid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            order_reg  <= ORDER_RESET;
            exp_reg    <= '0;
            tgt_reg    <= 1'b0;
            i_reg      <= '0;
            j_reg      <= '0;
            k_reg      <= '0;
            kdone_reg  <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            exp_reg    <= exp_next;
            tgt_reg    <= tgt_next;
            i_reg      <= i_next;
            j_reg      <= j_next;
            k_reg      <= k_next;
            kdone_reg  <= kdone_next;
            ovalid_reg <= ovalid_next;
            if (cfg_we)
            begin
                order_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign term_in.ready   = (state_reg == ST_IDLE) && !ovalid_reg;
    assign term_out.valid  = ovalid_reg;
    assign term_out.data   = res_reg;

    ap_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !term_in.ready)
        else $error("input ready while busy");
    ap_exp_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN) |-> (exp_reg == '0))
        else $error("final step with exponent left");
    ap_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && !term_out.ready) |=> (ovalid_reg && $stable(res_reg)))
        else $error("result dropped under stall");

endmodule

`default_nettype wire
